// File: rtl/apn_pkg.sv
// Shared constants and types for the adaptive palette nearest-color block.
// No dependencies; imported by every module in rtl/.
package apn_pkg;

  localparam int MAX_ENTRIES = 255;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int THRESH_W    = 18;
  localparam int OUT_IDX_W   = 8;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(48);
  localparam logic [COUNT_W-1:0]  COUNT_FULL   = COUNT_W'(MAX_ENTRIES);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic valid;
    idx_t idx;
  } tag_t;

endpackage

// File: rtl/apn_palette_ram.sv
// Palette memory: MAX_ENTRIES x 24 bits, one write port, one registered read port.
// Depends on apn_pkg.
module apn_palette_ram
  import apn_pkg::*;
(
  input  logic   clk,
  input  logic   wr_en,
  input  idx_t   wr_addr,
  input  color_t wr_data,
  input  logic   rd_en,
  input  idx_t   rd_addr,
  output color_t rd_data
);

  color_t mem [MAX_ENTRIES];
  color_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/apn_dist.sv
// Two-stage squared color distance: channel squares, then their sum.
// Depends on apn_pkg.
module apn_dist
  import apn_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  tag_t   in_tag,
  input  color_t color_a,
  input  color_t color_b,
  output tag_t   out_tag,
  output dist_t  out_dist,
  output logic   pipe_busy
);

  logic [SQ_W-1:0]   sq_nxt [3];
  logic [SQ_W-1:0]   sq_r   [3];
  tag_t              sq_tag_r;
  tag_t              dist_tag_r;
  dist_t             dist_r;

  always_comb begin
    logic [CHAN_W-1:0] a, b, d;
    for (int c = 0; c < 3; c++) begin
      a = color_a[c*CHAN_W +: CHAN_W];
      b = color_b[c*CHAN_W +: CHAN_W];
      d = (a > b) ? (a - b) : (b - a);
      sq_nxt[c] = SQ_W'(d) * SQ_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_tag_r.valid   <= 1'b0;
      dist_tag_r.valid <= 1'b0;
    end else begin
      sq_tag_r.valid   <= in_tag.valid;
      dist_tag_r.valid <= sq_tag_r.valid;
    end
    sq_tag_r.idx   <= in_tag.idx;
    dist_tag_r.idx <= sq_tag_r.idx;
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= sq_nxt[c];
    end
    dist_r <= DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  end

  assign out_tag   = dist_tag_r;
  assign out_dist  = dist_r;
  assign pipe_busy = sq_tag_r.valid | dist_tag_r.valid;

endmodule

// File: rtl/adaptive_palette_nearest_color_top.sv
// Each accepted item (start high, busy low) scans every stored palette entry, one
// memory read per cycle, through a pipelined squared-distance unit, then either
// reuses the nearest entry or appends the color. An item passes through one read per
// stored entry, then the memory read, the two distance stages, one drain check,
// the decision and the output register; with an empty palette it goes straight
// to the decision. The result appears for one cycle with out_valid, which the
// receiver must take; the next item may be started in that same cycle.
// Depends on apn_pkg, apn_palette_ram and apn_dist.
module adaptive_palette_nearest_color_top
  import apn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COLOR_W-1:0]   in_color,
  output logic                 out_valid,
  output logic [OUT_IDX_W-1:0] out_palette_index,
  output logic                 out_was_added,
  input  logic                 cfg_we,
  input  logic [THRESH_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  state_t                state_r;
  logic [THRESH_W-1:0]   thresh_r;
  color_t                color_r;
  logic [COUNT_W-1:0]    count_r;
  logic [COUNT_W-1:0]    rd_addr_r;
  tag_t                  rd_tag_r;
  logic                  found_r;
  idx_t                  best_idx_r;
  dist_t                 best_dist_r;
  logic                  out_valid_r;
  logic [OUT_IDX_W-1:0]  out_index_r;
  logic                  out_added_r;

  logic                  rd_en;
  logic                  wr_en;
  color_t                rd_data;
  tag_t                  dist_tag;
  dist_t                 cur_dist;
  logic                  pipe_busy;
  logic                  hit;
  logic [COUNT_W-1:0]    rd_addr_inc;
  logic [IDX_W+OUT_IDX_W-1:0] best_wide;
  logic [COUNT_W+OUT_IDX_W-1:0] count_wide;

  assign rd_en       = (state_r == ST_SCAN);
  assign rd_addr_inc = rd_addr_r + COUNT_W'(1);
  assign hit         = (found_r && (THRESH_W'(best_dist_r) < thresh_r))
                       || (count_r >= COUNT_FULL);
  assign wr_en       = (state_r == ST_DECIDE) && !hit;
  assign best_wide   = {{OUT_IDX_W{1'b0}}, best_idx_r};
  assign count_wide  = {{OUT_IDX_W{1'b0}}, count_r};

  apn_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (color_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  apn_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (rd_tag_r),
    .color_a   (color_r),
    .color_b   (rd_data),
    .out_tag   (dist_tag),
    .out_dist  (cur_dist),
    .pipe_busy (pipe_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      thresh_r       <= THRESH_RESET;
      count_r        <= '0;
      rd_tag_r.valid <= 1'b0;
      found_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      out_valid_r    <= 1'b0;
      rd_tag_r.valid <= rd_en;

      if (dist_tag.valid && (!found_r || cur_dist < best_dist_r)) begin
        found_r     <= 1'b1;
        best_dist_r <= cur_dist;
        best_idx_r  <= dist_tag.idx;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            color_r   <= in_color;
            rd_addr_r <= '0;
            found_r   <= 1'b0;
            state_r   <= (count_r == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_addr_r <= rd_addr_inc;
          if (rd_addr_inc == count_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_tag_r.valid && !pipe_busy && !dist_tag.valid) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          out_valid_r <= 1'b1;
          if (hit) begin
            out_index_r <= best_wide[OUT_IDX_W-1:0];
            out_added_r <= 1'b0;
          end else begin
            out_index_r <= count_wide[OUT_IDX_W-1:0];
            out_added_r <= 1'b1;
            count_r     <= count_r + COUNT_W'(1);
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    rd_tag_r.idx <= rd_addr_r[IDX_W-1:0];
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_palette_index = out_index_r;
  assign out_was_added     = out_added_r;

endmodule

// File: verif/palette_nearest_checker.sv
// Checker for the adaptive palette nearest-color block: keeps its own palette and
// threshold, predicts index and append flag per accepted item, compares each result.
// Depends on apn_pkg; instantiated beside the block by tb_adaptive_palette_nearest_color_top.
module palette_nearest_checker
  import apn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  color_t               in_color,
  input  logic                 out_valid,
  input  logic [OUT_IDX_W-1:0] out_palette_index,
  input  logic                 out_was_added,
  input  logic                 cfg_we,
  input  logic [THRESH_W-1:0]  cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic                 added;
  } pick_t;

  color_t              palette_copy [MAX_ENTRIES];
  int unsigned         used_entries = 0;
  logic [THRESH_W-1:0] threshold = THRESH_RESET;
  pick_t               expected_picks [$];
  int                  fail_count = 0;

  assign mismatches = fail_count;

  function automatic int unsigned chan_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int unsigned d;
    d = (a > b) ? int'(a - b) : int'(b - a);
    return d * d;
  endfunction

  function automatic int unsigned color_dist(color_t x, color_t y);
    return chan_sq(x[23:16], y[23:16]) + chan_sq(x[15:8], y[15:8]) + chan_sq(x[7:0], y[7:0]);
  endfunction

  // Nearest search with earliest entry on ties; append when nothing is close enough.
  function automatic pick_t quantize_color(color_t c);
    int unsigned best;
    int unsigned best_dist;
    int unsigned d;
    bit          found;
    pick_t       r;
    found     = 1'b0;
    best      = 0;
    best_dist = 0;
    for (int unsigned i = 0; i < used_entries; i++) begin
      d = color_dist(c, palette_copy[i]);
      if (!found || d < best_dist) begin
        found     = 1'b1;
        best_dist = d;
        best      = i;
      end
    end
    if ((found && best_dist < threshold) || used_entries >= MAX_ENTRIES) begin
      r.index = best[OUT_IDX_W-1:0];
      r.added = 1'b0;
    end else begin
      palette_copy[used_entries] = c;
      r.index = used_entries[OUT_IDX_W-1:0];
      r.added = 1'b1;
      used_entries++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pick_t want;
    if (!rst_n) begin
      used_entries = 0;
      threshold    = THRESH_RESET;
      expected_picks.delete();
    end else begin
      if (out_valid) begin
        if (expected_picks.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual index %0d added %0b",
                   $time, out_palette_index, out_was_added);
        end else begin
          want = expected_picks.pop_front();
          if (out_palette_index !== want.index) begin
            fail_count++;
            $display("%0t: palette_index expected %0d actual %0d",
                     $time, want.index, out_palette_index);
          end
          if (out_was_added !== want.added) begin
            fail_count++;
            $display("%0t: was_added expected %0b actual %0b",
                     $time, want.added, out_was_added);
          end
        end
      end
      if (cfg_we) threshold = cfg_wdata;
      if (start && !busy) expected_picks.push_back(quantize_color(in_color));
    end
    outstanding <= expected_picks.size();
  end

endmodule

// File: verif/tb_adaptive_palette_nearest_color_top.sv
// Testbench top for adaptive_palette_nearest_color_top: clock, reset, color and
// threshold stimulus, verdict. Depends on apn_pkg, the block and palette_nearest_checker.
module tb_adaptive_palette_nearest_color_top;
  import apn_pkg::*;

  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 117;
  localparam int DRAIN_CYCLES    = 300;

  localparam logic [THRESH_W-1:0] THRESH_NONE      = '0;
  localparam logic [THRESH_W-1:0] THRESH_EXACT     = THRESH_W'(1);
  localparam logic [THRESH_W-1:0] THRESH_MAX_DIST  = THRESH_W'(195076);
  localparam logic [THRESH_W-1:0] THRESH_ALL_ONES  = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  color_t               in_color;
  logic                 out_valid;
  logic [OUT_IDX_W-1:0] out_palette_index;
  logic                 out_was_added;
  logic                 cfg_we;
  logic [THRESH_W-1:0]  cfg_wdata;
  int                   mismatches;
  int                   outstanding;
  int                   cycle_count = 0;
  int                   no_gap_items = 0;
  color_t               sent_colors [$];

  adaptive_palette_nearest_color_top i_dut (.*);

  palette_nearest_checker i_pick_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_adaptive_palette_nearest_color_top NOT OK");
      $finish;
    end
  end

  function automatic logic [THRESH_W-1:0] phase_threshold(int p);
    case (p)
      0: return THRESH_RESET;
      1: return THRESH_W'(300);
      2: return THRESH_EXACT;
      3: return THRESH_NONE;
      4: return THRESH_W'(2000);
      5: return THRESH_MAX_DIST;
      6: return THRESH_NONE;
      default: return THRESH_W'($urandom_range(0, 2 ** THRESH_W - 1));
    endcase
  endfunction

  // Mix of fresh colors, repeats, near neighbors and channel extremes.
  function automatic color_t random_color();
    int     kind;
    int     v;
    color_t c;
    kind = $urandom_range(0, 99);
    if (sent_colors.size() == 0 || kind >= 60) return color_t'($urandom);
    c = sent_colors[$urandom_range(0, sent_colors.size() - 1)];
    if (kind < 15) return c;
    for (int k = 0; k < 3; k++) begin
      if (kind < 50) begin
        v = int'(c[CHAN_W*k +: CHAN_W]) + int'($urandom_range(0, 12)) - 6;
        v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      end else begin
        case ($urandom_range(0, 2))
          0: v = 0;
          1: v = 255;
          default: v = $urandom_range(0, 255);
        endcase
      end
      c[CHAN_W*k +: CHAN_W] = v[CHAN_W-1:0];
    end
    return c;
  endfunction

  task automatic send_color(color_t c);
    int gap;
    if (no_gap_items > 0) begin
      no_gap_items--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 29) == 0) no_gap_items = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_color <= c;
    sent_colors.push_back(c);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_threshold(logic [THRESH_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_color  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold: empty palette, exact hit, near hit, tie, primaries
    send_color(24'h000000);
    send_color(24'h000000);
    send_color(24'hFFFFFF);
    send_color(24'h000006);
    send_color(24'h00000A);
    send_color(24'h000005);
    send_color(24'hFF0000);
    send_color(24'h00FF00);
    send_color(24'h0000FF);
    send_color(24'hFFFFF9);
    write_threshold(THRESH_MAX_DIST);
    send_color(24'h808080);
    send_color(24'h7F7F7F);
    write_threshold(THRESH_NONE);
    send_color(24'h000000);
    send_color(24'hFFFFFF);
    write_threshold(THRESH_ALL_ONES);
    send_color(24'h123456);
    write_threshold(THRESH_EXACT);
    send_color(24'h000000);
    send_color(24'h000001);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_threshold(phase_threshold(p));
      repeat (ITEMS_PER_PHASE) send_color(random_color());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_adaptive_palette_nearest_color_top OK");
    end else begin
      $display("tb_adaptive_palette_nearest_color_top NOT OK");
    end
    $finish;
  end

endmodule
